[rtl/core/rcmc_pkg.sv]
package rcmc_pkg;

  localparam int MOD_W       = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CHAR_W      = 7;
  localparam int RES_W       = 17;
  localparam int OUT_CHAR_W  = 8;
  localparam int EXP_W       = 16;
  localparam int CHAR_OFFSET = 96;

  localparam int DIV_W     = (2 * MOD_W > RES_W) ? 2 * MOD_W : RES_W;
  localparam int RED_CNT_W = $clog2(DIV_W);
  localparam int EXP_CNT_W = $clog2(EXP_W);

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS  = 2'd0,
    REG_PUB_EXP  = 2'd1,
    REG_PRIV_EXP = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_ONE,
    DP_ZERO,
    DP_SQ,
    DP_MUL,
    DP_RED,
    DP_WB_B,
    DP_WB_R,
    DP_SHIFT,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic exp_zero;
    logic n_zero;
    logic exp_msb;
  } dp_status_t;

endpackage

[rtl/core/rcmc_if.sv]
interface rcmc_item_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [rcmc_pkg::CHAR_W-1:0]      char_in;
  logic signed [rcmc_pkg::RES_W-1:0] residue_in;

  modport source (output valid, op, char_in, residue_in, input ready);
  modport sink (input valid, op, char_in, residue_in, output ready);
endinterface

interface rcmc_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [rcmc_pkg::RES_W-1:0]   residue_out;
  logic [rcmc_pkg::OUT_CHAR_W-1:0]     char_out;

  modport source (output valid, residue_out, char_out, input ready);
  modport sink (input valid, residue_out, char_out, output ready);
endinterface

interface rcmc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rcmc_pkg::CFG_IDX_W-1:0] index;
  logic [rcmc_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/rcmc_datapath.sv]
module rcmc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  rcmc_cfg_if.sink                            cfg,
  input  logic                                op,
  input  logic [rcmc_pkg::CHAR_W-1:0]         char_in,
  input  logic signed [rcmc_pkg::RES_W-1:0]   residue_in,
  input  rcmc_pkg::dp_op_t                    cmd,
  output rcmc_pkg::dp_status_t                status,
  output logic signed [rcmc_pkg::RES_W-1:0]   residue_out,
  output logic [rcmc_pkg::OUT_CHAR_W-1:0]     char_out
);

  logic [rcmc_pkg::CFG_W-1:0]     modulus;
  logic [rcmc_pkg::CFG_W-1:0]     pub_exp;
  logic [rcmc_pkg::CFG_W-1:0]     priv_exp;

  logic                           neg;
  logic                           exp_odd;
  logic [rcmc_pkg::EXP_W-1:0]     exp;
  logic [rcmc_pkg::MOD_W-1:0]     n;
  logic [rcmc_pkg::MOD_W-1:0]     b;
  logic [rcmc_pkg::MOD_W-1:0]     r;
  logic [rcmc_pkg::DIV_W-1:0]     div;
  logic [rcmc_pkg::MOD_W-1:0]     rem;
  logic [rcmc_pkg::RES_W-1:0]     res;

  logic                           enc_neg;
  logic [rcmc_pkg::RES_W-1:0]     enc_mag;
  logic [rcmc_pkg::RES_W-1:0]     rin_u;
  logic                           dec_neg;
  logic [rcmc_pkg::RES_W-1:0]     dec_mag;
  logic [rcmc_pkg::EXP_W-1:0]     sel_exp;

  logic [rcmc_pkg::MOD_W:0]       rem_sh;
  logic [rcmc_pkg::MOD_W:0]       n_ext;
  logic [rcmc_pkg::MOD_W:0]       rem_diff;
  logic [rcmc_pkg::MOD_W-1:0]     rem_new;

  logic [rcmc_pkg::MOD_W-1:0]     mul_b;
  logic [2*rcmc_pkg::MOD_W-1:0]   prod;

  logic [rcmc_pkg::RES_W-1:0]     r_ext;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= rcmc_pkg::CFG_W'(143);
      pub_exp  <= rcmc_pkg::CFG_W'(7);
      priv_exp <= rcmc_pkg::CFG_W'(103);
    end else if (cfg.valid) begin
      case (rcmc_pkg::cfg_reg_t'(cfg.index))
        rcmc_pkg::REG_MODULUS:  modulus  <= cfg.data;
        rcmc_pkg::REG_PUB_EXP:  pub_exp  <= cfg.data;
        rcmc_pkg::REG_PRIV_EXP: priv_exp <= cfg.data;
        default: ;
      endcase
    end
  end

  // signed base: character minus offset, or the raw residue
  always_comb begin
    enc_neg = char_in < rcmc_pkg::CHAR_W'(rcmc_pkg::CHAR_OFFSET);
    enc_mag = enc_neg ?
      rcmc_pkg::RES_W'(rcmc_pkg::CHAR_OFFSET) - rcmc_pkg::RES_W'(char_in) :
      rcmc_pkg::RES_W'(char_in) - rcmc_pkg::RES_W'(rcmc_pkg::CHAR_OFFSET);
    rin_u   = residue_in;
    dec_neg = rin_u[rcmc_pkg::RES_W-1];
    dec_mag = dec_neg ? rcmc_pkg::RES_W'(0) - rin_u : rin_u;
    sel_exp = (op == rcmc_pkg::OP_DECRYPT) ? priv_exp : pub_exp;
  end

  // one restoring remainder step per cycle
  always_comb begin
    rem_sh   = {rem, div[rcmc_pkg::DIV_W-1]};
    n_ext    = {1'b0, n};
    rem_diff = rem_sh - n_ext;
    rem_new  = (rem_sh >= n_ext) ? rem_diff[rcmc_pkg::MOD_W-1:0] :
                                   rem_sh[rcmc_pkg::MOD_W-1:0];
  end

  always_comb begin
    mul_b = (cmd == rcmc_pkg::DP_MUL) ? b : r;
    prod  = (2*rcmc_pkg::MOD_W)'(r) * (2*rcmc_pkg::MOD_W)'(mul_b);
    r_ext = rcmc_pkg::RES_W'(r);
  end

  always_ff @(posedge clk) begin
    case (cmd)
      rcmc_pkg::DP_LOAD: begin
        neg     <= (op == rcmc_pkg::OP_DECRYPT) ? dec_neg : enc_neg;
        div     <= rcmc_pkg::DIV_W'((op == rcmc_pkg::OP_DECRYPT) ? dec_mag : enc_mag);
        rem     <= '0;
        exp     <= sel_exp;
        exp_odd <= sel_exp[0];
        n       <= rcmc_pkg::MOD_W'(modulus);
      end
      rcmc_pkg::DP_ONE:  res <= rcmc_pkg::RES_W'(1);
      rcmc_pkg::DP_ZERO: res <= '0;
      rcmc_pkg::DP_SQ, rcmc_pkg::DP_MUL: begin
        div <= rcmc_pkg::DIV_W'(prod);
        rem <= '0;
      end
      rcmc_pkg::DP_RED: begin
        div <= div << 1;
        rem <= rem_new;
      end
      rcmc_pkg::DP_WB_B: begin
        b <= rem;
        r <= rcmc_pkg::MOD_W'(1);
      end
      rcmc_pkg::DP_WB_R:  r <= rem;
      rcmc_pkg::DP_SHIFT: exp <= exp << 1;
      rcmc_pkg::DP_FINISH: begin
        res <= (neg && exp_odd && (r != '0)) ? rcmc_pkg::RES_W'(0) - r_ext : r_ext;
      end
      default: ;
    endcase
  end

  assign status.exp_zero = (exp == '0);
  assign status.n_zero   = (n == '0);
  assign status.exp_msb  = exp[rcmc_pkg::EXP_W-1];

  assign residue_out = res;
  assign char_out    = rcmc_pkg::OUT_CHAR_W'(res + rcmc_pkg::RES_W'(rcmc_pkg::CHAR_OFFSET));

endmodule

[rtl/core/rcmc_ctrl.sv]
module rcmc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  output logic                  result_valid,
  input  logic                  result_ready,
  input  rcmc_pkg::dp_status_t  status,
  output rcmc_pkg::dp_op_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SQ,
    S_MUL,
    S_RED,
    S_WB,
    S_NEXT,
    S_FIN,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_BASE,
    PH_SQ,
    PH_MUL
  } phase_t;

  state_t                           state;
  phase_t                           phase;
  logic [rcmc_pkg::RED_CNT_W-1:0]   red_cnt;
  logic [rcmc_pkg::EXP_CNT_W-1:0]   bit_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      phase   <= PH_BASE;
      red_cnt <= '0;
      bit_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (status.exp_zero || status.n_zero) begin
            state <= S_OUT;
          end else begin
            state   <= S_RED;
            phase   <= PH_BASE;
            red_cnt <= '0;
            bit_cnt <= '0;
          end
        end
        S_SQ: begin
          state   <= S_RED;
          phase   <= PH_SQ;
          red_cnt <= '0;
        end
        S_MUL: begin
          state   <= S_RED;
          phase   <= PH_MUL;
          red_cnt <= '0;
        end
        S_RED: begin
          if (red_cnt == rcmc_pkg::RED_CNT_W'(rcmc_pkg::DIV_W - 1)) begin
            state <= S_WB;
          end else begin
            red_cnt <= red_cnt + 1'b1;
          end
        end
        S_WB: begin
          case (phase)
            PH_BASE: state <= S_SQ;
            PH_SQ:   state <= status.exp_msb ? S_MUL : S_NEXT;
            default: state <= S_NEXT;
          endcase
        end
        S_NEXT: begin
          if (bit_cnt == rcmc_pkg::EXP_CNT_W'(rcmc_pkg::EXP_W - 1)) begin
            state <= S_FIN;
          end else begin
            bit_cnt <= bit_cnt + 1'b1;
            state   <= S_SQ;
          end
        end
        S_FIN: state <= S_OUT;
        S_OUT: begin
          if (result_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    case (state)
      S_IDLE:  cmd = item_valid ? rcmc_pkg::DP_LOAD : rcmc_pkg::DP_NOP;
      S_CHECK: cmd = status.exp_zero ? rcmc_pkg::DP_ONE :
                     status.n_zero   ? rcmc_pkg::DP_ZERO : rcmc_pkg::DP_NOP;
      S_SQ:    cmd = rcmc_pkg::DP_SQ;
      S_MUL:   cmd = rcmc_pkg::DP_MUL;
      S_RED:   cmd = rcmc_pkg::DP_RED;
      S_WB:    cmd = (phase == PH_BASE) ? rcmc_pkg::DP_WB_B : rcmc_pkg::DP_WB_R;
      S_NEXT:  cmd = rcmc_pkg::DP_SHIFT;
      S_FIN:   cmd = rcmc_pkg::DP_FINISH;
      default: cmd = rcmc_pkg::DP_NOP;
    endcase
  end

  assign item_ready   = (state == S_IDLE);
  assign result_valid = (state == S_OUT);

endmodule

[rtl/core/rsa_char_modexp_cipher_top.sv]
// Character RSA engine: one item at a time. Each item is raised to the public
// (encrypt) or private (decrypt) exponent modulo the modulus by square-and-multiply
// over all 16 exponent bits, MSB first, on one shared multiplier followed by a
// bit-serial remainder unit that retires one dividend bit per cycle. An item is
// loaded and checked, its base reduced, then each exponent bit takes a square and
// a reduction, plus a multiply and a reduction if the bit is set; the result then
// waits to be taken. A zero exponent gives 1, else a zero modulus gives 0. The
// next item is taken only after the result is delivered. Registers are to be
// written through cfg only while no item is in flight (up to the user): index 0
// modulus, 1 public exponent, 2 private exponent; other indexes are ignored.
module rsa_char_modexp_cipher_top (
  input  logic             clk,
  input  logic             rst,
  rcmc_item_if.sink        item,
  rcmc_result_if.source    result,
  rcmc_cfg_if.sink         cfg
);

  rcmc_pkg::dp_op_t     cmd;
  rcmc_pkg::dp_status_t status;

  rcmc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  rcmc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .op          (item.op),
    .char_in     (item.char_in),
    .residue_in  (item.residue_in),
    .cmd         (cmd),
    .status      (status),
    .residue_out (result.residue_out),
    .char_out    (result.char_out)
  );

endmodule
